FILE: hw/rtl/zero_cross_relay_switch_defines.svh
// assertion macros for the zero-cross relay switch
// used by the rtl files that carry assertions, expects clk and arst_n in scope
`ifndef ZERO_CROSS_RELAY_SWITCH_DEFINES_SVH
`define ZERO_CROSS_RELAY_SWITCH_DEFINES_SVH

// condition implies consequence in the same cycle
`define ZCRS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("zcrs same-cycle check failed");

// condition implies consequence in the next cycle
`define ZCRS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("zcrs next-cycle check failed");

`endif

FILE: hw/rtl/zcrs_pkg.sv
// types and constants of the zero-cross relay switch
// no dependencies
`default_nettype none

package zcrs_pkg;

	localparam int CNT_W = 16;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [CNT_W-1:0] TIMEOUT_RST   = 16'd100;
	localparam logic [CNT_W-1:0] DELAY_ON_RST  = 16'd1000;
	localparam logic [CNT_W-1:0] DELAY_OFF_RST = 16'd1000;

	typedef enum logic [1:0] {
		REQ_TICK = 2'd0,
		REQ_ON   = 2'd1,
		REQ_OFF  = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		REG_TIMEOUT   = 2'd0,
		REG_DELAY_ON  = 2'd1,
		REG_DELAY_OFF = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_OFF         = 3'd0,
		PH_WAIT_ON     = 3'd1,
		PH_DELAYED_ON  = 3'd2,
		PH_ON          = 3'd3,
		PH_WAIT_OFF    = 3'd4,
		PH_DELAYED_OFF = 3'd5
	} phase_t;

	typedef struct packed {
		logic [CNT_W-1:0] timeout_ticks;
		logic [CNT_W-1:0] delay_on_ticks;
		logic [CNT_W-1:0] delay_off_ticks;
	} cfg_t;

	typedef struct packed {
		logic       relay_drive;
		logic       sync_level;
		logic       is_on;
		logic       is_off;
		logic [2:0] phase;
	} result_t;

	function automatic logic phase_is_on(input phase_t ph);
		return (ph == PH_WAIT_ON) || (ph == PH_DELAYED_ON) || (ph == PH_ON);
	endfunction

	function automatic logic phase_is_off(input phase_t ph);
		return (ph == PH_WAIT_OFF) || (ph == PH_DELAYED_OFF) || (ph == PH_OFF);
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/zcrs_in_if.sv
// input channel of the zero-cross relay switch: request or tick with pin sample
// no dependencies
`default_nettype none

interface zcrs_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic       sync_pin;

	modport source (output valid, output req_type, output sync_pin, input ready);
	modport sink   (input valid, input req_type, input sync_pin, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/zcrs_out_if.sv
// result channel of the zero-cross relay switch
// no dependencies
`default_nettype none

interface zcrs_out_if;
	logic       valid;
	logic       ready;
	logic       relay_drive;
	logic       sync_level;
	logic       is_on;
	logic       is_off;
	logic [2:0] phase;

	modport source (
		output valid, output relay_drive, output sync_level,
		output is_on, output is_off, output phase, input ready
	);
	modport sink (
		input valid, input relay_drive, input sync_level,
		input is_on, input is_off, input phase, output ready
	);
endinterface

`default_nettype wire

FILE: hw/rtl/zcrs_cfg_if.sv
// configuration write channel of the zero-cross relay switch
// no dependencies
`default_nettype none

interface zcrs_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/zcrs_core.sv
// phase state machine, edge tracker and tick counters of the relay switch
// depends on zcrs_pkg and zero_cross_relay_switch_defines.svh
`default_nettype none
`include "zero_cross_relay_switch_defines.svh"

module zcrs_core
	import zcrs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [1:0] req_type,
	input  wire logic       sync_pin,
	input  wire cfg_t       cfg,
	output result_t         res_nxt
);

	phase_t           phase_q, phase_nxt;
	logic             last_level_q, last_level_nxt;
	logic [CNT_W-1:0] timeout_q, timeout_nxt;
	logic [CNT_W-1:0] delay_q, delay_nxt;
	logic             relay_q, relay_nxt;
	logic             fall_seen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_OFF;
			last_level_q <= 1'b0;
			timeout_q    <= '0;
			delay_q      <= '0;
			relay_q      <= 1'b0;
		end else if (accept) begin
			phase_q      <= phase_nxt;
			last_level_q <= last_level_nxt;
			timeout_q    <= timeout_nxt;
			delay_q      <= delay_nxt;
			relay_q      <= relay_nxt;
		end
	end

	always_comb begin
		phase_nxt      = phase_q;
		last_level_nxt = last_level_q;
		timeout_nxt    = timeout_q;
		delay_nxt      = delay_q;
		relay_nxt      = relay_q;
		fall_seen      = 1'b0;

		case (req_type)
			REQ_TICK: begin
				// counters advance before the phase logic looks at them
				if (timeout_q != '0)
					timeout_nxt = timeout_q - 1'b1;
				if (delay_q != CNT_MAX)
					delay_nxt = delay_q + 1'b1;

				if (!last_level_q && sync_pin) begin
					last_level_nxt = 1'b1;
				end else if (last_level_q && !sync_pin) begin
					last_level_nxt = 1'b0;
					fall_seen      = 1'b1;
				end

				case (phase_q)
					PH_OFF, PH_ON: begin
					end
					PH_WAIT_ON: begin
						if (fall_seen) begin
							phase_nxt = PH_DELAYED_ON;
							delay_nxt = '0;
						end
						// timeout wins over an edge on the same tick
						if (timeout_nxt == '0) begin
							relay_nxt = 1'b1;
							phase_nxt = PH_ON;
						end
					end
					PH_DELAYED_ON: begin
						if (delay_nxt > cfg.delay_on_ticks) begin
							relay_nxt = 1'b1;
							phase_nxt = PH_ON;
						end
					end
					PH_WAIT_OFF: begin
						if (fall_seen) begin
							phase_nxt = PH_DELAYED_OFF;
							delay_nxt = '0;
						end
						if (timeout_nxt == '0) begin
							relay_nxt = 1'b0;
							phase_nxt = PH_OFF;
						end
					end
					PH_DELAYED_OFF: begin
						if (delay_nxt > cfg.delay_off_ticks) begin
							relay_nxt = 1'b0;
							phase_nxt = PH_OFF;
						end
					end
					default: begin
						relay_nxt = 1'b0;
						phase_nxt = PH_OFF;
					end
				endcase
			end
			REQ_ON: begin
				if (!phase_is_on(phase_q)) begin
					phase_nxt   = PH_WAIT_ON;
					timeout_nxt = cfg.timeout_ticks;
				end
			end
			REQ_OFF: begin
				if (!phase_is_off(phase_q)) begin
					phase_nxt   = PH_WAIT_OFF;
					timeout_nxt = cfg.timeout_ticks;
				end
			end
			default: begin
			end
		endcase

		res_nxt.relay_drive = relay_nxt;
		res_nxt.sync_level  = last_level_nxt;
		res_nxt.is_on       = phase_is_on(phase_nxt);
		res_nxt.is_off      = phase_is_off(phase_nxt);
		res_nxt.phase       = phase_nxt;
	end

	`ZCRS_ASSERT_IMP(a_on_closed, phase_q == PH_ON, relay_q)
	`ZCRS_ASSERT_IMP(a_off_open, phase_q == PH_OFF, !relay_q)
	`ZCRS_ASSERT_NXT(a_hold_idle, !accept, $stable(phase_q) && $stable(timeout_q))

endmodule

`default_nettype wire

FILE: hw/rtl/zero_cross_relay_switch.sv
// zero-cross relay switch top level: configuration registers, core and result buffer
// depends on zcrs_pkg, zcrs_in_if, zcrs_out_if, zcrs_cfg_if, zcrs_core and the defines header
//
// usage
// - item channel carries req_type and sync_pin: a tick with the sampled sync pin,
//   an on request or an off request; unused code 3 leaves the state alone
// - result channel returns one result per item transfer: relay_drive, sync_level,
//   is_on, is_off and phase, all taken after the update
// - cfg channel writes timeout_ticks (index 0), delay_on_ticks (1), delay_off_ticks (2);
//   index 3 is dropped; it is always ready and writes land at once
// - each result is registered, in the output register or, while that one is held, in the skid entry
// - the block takes one item per cycle while item ready is high
// - a two-entry result buffer (output register plus skid) lets an item transfer
//   while one result is still held; item ready drops only while both are full
// - when the receiver stalls the held result stays on the port unchanged
// - reset sets the registers to 100, 1000 and 1000, the phase to off with the relay
//   open, clears the counters and empties the result buffer
`default_nettype none
`include "zero_cross_relay_switch_defines.svh"

module zero_cross_relay_switch
	import zcrs_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	zcrs_in_if.sink    item,
	zcrs_out_if.source result,
	zcrs_cfg_if.sink   cfg
);

	cfg_t    cfg_q;
	result_t res_nxt;
	result_t out_q, skid_q;
	logic    out_valid_q, skid_valid_q;
	logic    item_xfer;
	logic    out_free;

	// configuration registers, always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks   <= TIMEOUT_RST;
			cfg_q.delay_on_ticks  <= DELAY_ON_RST;
			cfg_q.delay_off_ticks <= DELAY_OFF_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_TIMEOUT:   cfg_q.timeout_ticks   <= cfg.data;
				REG_DELAY_ON:  cfg_q.delay_on_ticks  <= cfg.data;
				REG_DELAY_OFF: cfg_q.delay_off_ticks <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// item side: blocked only while the skid entry is occupied
	assign item.ready = !skid_valid_q;
	assign item_xfer  = item.valid && item.ready;

	zcrs_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (item_xfer),
		.req_type (item.req_type),
		.sync_pin (item.sync_pin),
		.cfg      (cfg_q),
		.res_nxt  (res_nxt)
	);

	// output register can take a new entry when empty or being drained
	assign out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q  <= skid_valid_q || item_xfer;
				skid_valid_q <= 1'b0;
			end else if (item_xfer) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (item_xfer)
				out_q <= res_nxt;
		end else if (item_xfer) begin
			skid_q <= res_nxt;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.relay_drive = out_q.relay_drive;
	assign result.sync_level  = out_q.sync_level;
	assign result.is_on       = out_q.is_on;
	assign result.is_off      = out_q.is_off;
	assign result.phase       = out_q.phase;

	`ZCRS_ASSERT_IMP(a_skid_behind_out, skid_valid_q, out_valid_q)
	`ZCRS_ASSERT_NXT(a_xfer_to_out, item_xfer && out_free, out_valid_q && !skid_valid_q)
	`ZCRS_ASSERT_NXT(a_xfer_to_skid, item_xfer && !out_free, skid_valid_q && out_valid_q)

endmodule

`default_nettype wire

FILE: sim/zero_cross_relay_switch_check.sv
// result checker for the zero-cross relay switch: tracks the relay state per transfer
// depends on zcrs_pkg and the zcrs_in_if, zcrs_out_if and zcrs_cfg_if interfaces
`default_nettype none

module zero_cross_relay_switch_check
	import zcrs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	zcrs_in_if   item,
	zcrs_out_if  result,
	zcrs_cfg_if  cfg,
	output int   fail_count,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [CNT_W-1:0] timeout_set;
	logic [CNT_W-1:0] delay_on_set;
	logic [CNT_W-1:0] delay_off_set;

	phase_t           ph;
	logic             sync_q;
	logic             relay_q;
	logic [CNT_W-1:0] timeout_left;
	logic [CNT_W-1:0] delay_run;

	result_t status_q[$];

	function automatic logic closing_side(input phase_t p);
		return (p == PH_WAIT_ON) || (p == PH_DELAYED_ON) || (p == PH_ON);
	endfunction

	function automatic logic opening_side(input phase_t p);
		return (p == PH_WAIT_OFF) || (p == PH_DELAYED_OFF) || (p == PH_OFF);
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("relay check: %s got %0d want %0d at %0t", what, got, want, $time);
		fail_count++;
	endtask

	// advances the tracked relay state by one item, returns the status seen after it
	function automatic result_t relay_step(input logic [1:0] req, input logic pin);
		logic    crossing;
		result_t r;
		crossing = 1'b0;
		case (req)
		REQ_TICK: begin
			if (timeout_left != '0)
				timeout_left--;
			if (delay_run != CNT_MAX)
				delay_run++;
			if (!sync_q && pin) begin
				sync_q = 1'b1;
			end else if (sync_q && !pin) begin
				sync_q   = 1'b0;
				crossing = 1'b1;
			end
			case (ph)
			PH_OFF, PH_ON: ;
			PH_WAIT_ON: begin
				if (crossing) begin
					ph        = PH_DELAYED_ON;
					delay_run = '0;
				end
				// timeout wins over a crossing on the same tick
				if (timeout_left == '0) begin
					relay_q = 1'b1;
					ph      = PH_ON;
				end
			end
			PH_DELAYED_ON: begin
				if (delay_run > delay_on_set) begin
					relay_q = 1'b1;
					ph      = PH_ON;
				end
			end
			PH_WAIT_OFF: begin
				if (crossing) begin
					ph        = PH_DELAYED_OFF;
					delay_run = '0;
				end
				if (timeout_left == '0) begin
					relay_q = 1'b0;
					ph      = PH_OFF;
				end
			end
			PH_DELAYED_OFF: begin
				if (delay_run > delay_off_set) begin
					relay_q = 1'b0;
					ph      = PH_OFF;
				end
			end
			default: begin
				relay_q = 1'b0;
				ph      = PH_OFF;
			end
			endcase
		end
		REQ_ON: begin
			if (!closing_side(ph)) begin
				ph           = PH_WAIT_ON;
				timeout_left = timeout_set;
			end
		end
		REQ_OFF: begin
			if (!opening_side(ph)) begin
				ph           = PH_WAIT_OFF;
				timeout_left = timeout_set;
			end
		end
		default: ;
		endcase
		r.relay_drive = relay_q;
		r.sync_level  = sync_q;
		r.is_on       = closing_side(ph);
		r.is_off      = opening_side(ph);
		r.phase       = ph;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			timeout_set   = TIMEOUT_RST;
			delay_on_set  = DELAY_ON_RST;
			delay_off_set = DELAY_OFF_RST;
			ph            = PH_OFF;
			sync_q        = 1'b0;
			relay_q       = 1'b0;
			timeout_left  = '0;
			delay_run     = '0;
			status_q.delete();
			fail_count    = 0;
			pending       = 0;
		end else begin
			// older transfers first, so a result never matches an item of the same edge
			if (result.valid && result.ready) begin
				if (status_q.size() == 0) begin
					flag_mismatch("result with nothing pending", 1, 0);
				end else begin
					want = status_q.pop_front();
					if (result.relay_drive !== want.relay_drive)
						flag_mismatch("relay_drive", result.relay_drive, want.relay_drive);
					if (result.sync_level !== want.sync_level)
						flag_mismatch("sync_level", result.sync_level, want.sync_level);
					if (result.is_on !== want.is_on)
						flag_mismatch("is_on", result.is_on, want.is_on);
					if (result.is_off !== want.is_off)
						flag_mismatch("is_off", result.is_off, want.is_off);
					if (result.phase !== want.phase)
						flag_mismatch("phase", result.phase, want.phase);
				end
			end
			if (item.valid && item.ready)
				status_q.push_back(relay_step(item.req_type, item.sync_pin));
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
				REG_TIMEOUT:   timeout_set   = cfg.data;
				REG_DELAY_ON:  delay_on_set  = cfg.data;
				REG_DELAY_OFF: delay_off_set = cfg.data;
				default: ;
				endcase
			end
			pending = status_q.size();
		end
	end

endmodule

`default_nettype wire

FILE: sim/zero_cross_relay_switch_tb.sv
// testbench top for the zero-cross relay switch: clock, reset, stimulus and verdict
// depends on zcrs_pkg, the three channel interfaces, the block and zero_cross_relay_switch_check
`default_nettype none

module zero_cross_relay_switch_tb;
	import zcrs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// codes the package leaves unnamed: the spare request and the spare register slot
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [1:0] REG_SPARE  = 2'd3;

	// cycles with no transfer on any channel before the run is called hung
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int ITEMS_PER_PHASE = 92;
	localparam int PHASES          = 6;

	// register settings for the random phases: small values so delays really elapse,
	// plus the extremes (zero timeout, never-ending timeout, never-elapsing delays)
	localparam logic [15:0] PHASE_TMO [PHASES] = '{16'd4, 16'd0, 16'd65535, 16'd2, 16'd7, 16'd1};
	localparam logic [15:0] PHASE_DON [PHASES] = '{16'd3, 16'd0, 16'd1, 16'd65535, 16'd0, 16'd6};
	localparam logic [15:0] PHASE_DOFF[PHASES] = '{16'd2, 16'd0, 16'd5, 16'd0, 16'd65535, 16'd3};

	logic clk;
	logic arst_n;

	zcrs_in_if  item_ch();
	zcrs_out_if result_ch();
	zcrs_cfg_if cfg_ch();

	int check_fails;
	int check_pending;

	// idling knobs, percent of cycles
	int send_idle_pct = 0;
	int stall_pct     = 0;

	// mains square wave seen by the sync pin during the random part
	logic mains_level = 1'b0;
	int   half_left   = 1;

	int stalled_cycles;

	zero_cross_relay_switch dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	zero_cross_relay_switch_check relay_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_ch),
		.result     (result_ch),
		.cfg        (cfg_ch),
		.fail_count (check_fails),
		.pending    (check_pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver side: ready changes on the falling edge only
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready = ($urandom_range(99) >= stall_pct);
		end
	end

	// watchdog: any transfer on any channel restarts the count
	initial begin
		stalled_cycles = 0;
		while (stalled_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (item_ch.valid && item_ch.ready) ||
					(result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
				stalled_cycles = 0;
			else
				stalled_cycles++;
		end
		$display("zero_cross_relay_switch_tb: FAIL");
		$finish;
	end

	task automatic set_idling(input int mode);
		case (mode)
		0: begin send_idle_pct = 0;  stall_pct = 0;  end
		1: begin send_idle_pct = 82; stall_pct = 0;  end
		2: begin send_idle_pct = 0;  stall_pct = 82; end
		default: begin send_idle_pct = 13; stall_pct = 13; end
		endcase
	endtask

	// one item transfer; called and returns at a falling edge
	task automatic put_item(input logic [1:0] req, input logic pin);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid = 1'b0;
			@(negedge clk);
		end
		item_ch.valid    = 1'b1;
		item_ch.req_type = req;
		item_ch.sync_pin = pin;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
	endtask

	task automatic tick(input logic pin);
		put_item(REQ_TICK, pin);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data  = val;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// block idle: every result back, then a pause for the result buffer to settle
	task automatic drain();
		item_ch.valid = 1'b0;
		while (check_pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic program_regs(input logic [15:0] tmo, input logic [15:0] don,
			input logic [15:0] doff);
		drain();
		write_reg(REG_TIMEOUT, tmo);
		write_reg(REG_DELAY_ON, don);
		write_reg(REG_DELAY_OFF, doff);
	endtask

	// mostly ticks following a mains-like wave with a little pin noise,
	// now and then an on or off request, rarely the spare code
	task automatic random_item();
		int   r;
		logic pin;
		r = $urandom_range(99);
		if (r < 2) begin
			put_item(REQ_UNUSED, 1'($urandom_range(1)));
		end else if (r < 6) begin
			put_item(REQ_ON, 1'($urandom_range(1)));
		end else if (r < 10) begin
			put_item(REQ_OFF, 1'($urandom_range(1)));
		end else begin
			half_left--;
			if (half_left <= 0) begin
				mains_level = ~mains_level;
				half_left   = $urandom_range(5, 1);
			end
			pin = mains_level;
			if ($urandom_range(99) < 4)
				pin = ~pin;
			tick(pin);
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		item_ch.valid    = 1'b0;
		item_ch.req_type = REQ_TICK;
		item_ch.sync_pin = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = REG_TIMEOUT;
		cfg_ch.data      = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset registers: a crossing while off, a redundant off, the spare code
		set_idling(0);
		tick(1'b1);
		tick(1'b0);
		put_item(REQ_OFF, 1'b0);
		put_item(REQ_UNUSED, 1'b1);

		// short timeout, closing delay of two, zero opening delay; spare slot is dropped
		program_regs(16'd3, 16'd2, 16'd0);
		write_reg(REG_SPARE, 16'hffff);
		put_item(REQ_ON, 1'b0);
		put_item(REQ_ON, 1'b1);   // already on its way, ignored
		tick(1'b1);
		tick(1'b0);               // crossing, into delayed on
		tick(1'b0);
		tick(1'b0);
		tick(1'b0);               // delay passed, relay closes
		put_item(REQ_OFF, 1'b0);
		tick(1'b1);
		tick(1'b0);               // crossing, into delayed off
		tick(1'b0);               // zero delay opens on the next tick

		// off request while waiting on, then no crossing so the timeout opens it
		put_item(REQ_ON, 1'b0);
		put_item(REQ_OFF, 1'b0);
		tick(1'b0);
		tick(1'b0);
		tick(1'b0);

		// zero timeout closes on the first tick
		program_regs(16'd0, 16'd65535, 16'd0);
		put_item(REQ_ON, 1'b0);
		tick(1'b0);

		// crossing on the tick where the timeout runs out: timeout wins
		program_regs(16'd2, 16'd65535, 16'd0);
		put_item(REQ_OFF, 1'b0);
		tick(1'b1);
		tick(1'b0);

		// random part, one register setting and idling pattern per phase
		for (int p = 0; p < PHASES; p++) begin
			program_regs(PHASE_TMO[p], PHASE_DON[p], PHASE_DOFF[p]);
			set_idling(p % 4);
			repeat (ITEMS_PER_PHASE) random_item();
		end

		drain();
		if (check_fails == 0 && check_pending == 0)
			$display("zero_cross_relay_switch_tb: PASS");
		else
			$display("zero_cross_relay_switch_tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
